### src/cbr_pkg.sv
// Shared types, constants and helper functions of the census residual block.
package cbr_pkg;

	localparam int MAX_WIDTH_DEF      = 128;
	localparam int TEMPLATE_DEPTH_DEF = 16384;
	localparam int MAX_HEIGHT         = 128;
	localparam int ROW_W              = 7;
	localparam int DIM_W              = 8;
	localparam int PIX_W              = 8;
	localparam int NB_COUNT           = 8;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [DIM_W-1:0] dim_t;
	typedef logic signed [1:0] res_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// census bit (neighbor >= center) minus template bit, two's complement
	function automatic res_t residual(input pix_t nb, input pix_t ctr, input logic tbit);
		logic cbit;
		cbit = (nb >= ctr);
		return {~cbit & tbit, cbit ^ tbit};
	endfunction

	function automatic dim_t clamp_height(input dim_t v);
		dim_t r;
		if (v < dim_t'(3)) begin
			r = dim_t'(3);
		end else if (v > dim_t'(MAX_HEIGHT)) begin
			r = dim_t'(MAX_HEIGHT);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### src/cbr_intf.sv
// Channel interfaces: pixel/template stream, residual results, register writes.
interface cbr_stream_if;
	import cbr_pkg::*;

	logic valid;
	logic ready;
	cmd_t command;
	pix_t pixel;
	pix_t template_bits;
	logic start_of_frame;

	modport source (output valid, command, pixel, template_bits, start_of_frame, input ready);
	modport sink (input valid, command, pixel, template_bits, start_of_frame, output ready);
endinterface

interface cbr_result_if;
	import cbr_pkg::*;

	logic valid;
	logic ready;
	res_t residual_nw;
	res_t residual_n;
	res_t residual_ne;
	res_t residual_w;
	res_t residual_e;
	res_t residual_sw;
	res_t residual_s;
	res_t residual_se;
	logic last_of_frame;

	modport source (output valid, residual_nw, residual_n, residual_ne, residual_w,
		residual_e, residual_sw, residual_s, residual_se, last_of_frame, input ready);
	modport sink (input valid, residual_nw, residual_n, residual_ne, residual_w,
		residual_e, residual_sw, residual_s, residual_se, last_of_frame, output ready);
endinterface

interface cbr_cfg_if;
	import cbr_pkg::*;

	logic valid;
	logic ready;
	cfg_reg_t index;
	dim_t data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/census_bitplane_residual_top.sv
// 3x3 census transform of a pixel stream with residuals against a stored template.
//
// Channels: stream carries items with a command. A load item writes one template
// census byte at the next load address (start_of_frame restarts it at zero). A
// pixel item enters the raster scan (start_of_frame restarts column, row and
// template read position). When a pixel completes the 3x3 window of an interior
// center, one result item follows on result: eight residuals in -1..1 and
// last_of_frame on the last interior pixel. cfg writes image_width (index 0) and
// image_height (index 1); write only while the block is idle.
// A taken pixel is held in the window stage, then its result in the output register, where it is valid.
// Throughput: one item per cycle while no result stalls, set by the single read port of each
// line store and of the template memory, read at accept and used in the window stage.
// Reset: counters, window, line-store valid bits and registers return to their
// defaults at once; no clearing pass is needed. The template memory is not cleared.
// Stall: a waiting result is held in the output register; the window stage behind
// it still takes items that yield no result, and one more item may wait there.
module census_bitplane_residual_top #(
	parameter int MAX_WIDTH      = cbr_pkg::MAX_WIDTH_DEF,
	parameter int TEMPLATE_DEPTH = cbr_pkg::TEMPLATE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	cbr_stream_if.sink stream,
	cbr_result_if.source result,
	cbr_cfg_if.sink cfg
);
	import cbr_pkg::*;

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WID_W     = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W     = (WID_W > COL_W ? WID_W : COL_W) + 1;
	localparam int TA_W      = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1;
	localparam int WIDTH_RST = (MAX_WIDTH < 128) ? MAX_WIDTH : 128;
	localparam logic [TA_W-1:0] TA_LAST = TA_W'(TEMPLATE_DEPTH - 1);

	typedef logic [COL_W-1:0] col_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [TA_W-1:0]  taddr_t;

	// configuration
	logic [WID_W-1:0] width_q;
	dim_t             height_q;
	logic [WID_W-1:0] width_new;

	// scan counters
	col_t   col_q;
	row_t   row_q;
	taddr_t ra_q;
	taddr_t la_q;

	// memories
	pix_t upper_mem [MAX_WIDTH];
	pix_t middle_mem [MAX_WIDTH];
	pix_t tmpl_mem [TEMPLATE_DEPTH];
	logic [MAX_WIDTH-1:0] line_vld_q;

	// window stage
	logic s1_v_q;
	pix_t px_s1;
	col_t c_s1;
	logic prod_s1;
	logic last_s1;
	pix_t up_rd_s1;
	pix_t mid_rd_s1;
	logic vld_s1;
	logic fwd_s1;
	pix_t fwd_up_s1;
	pix_t fwd_mid_s1;
	pix_t tmpl_s1;
	pix_t win_q [6];

	// output register
	logic o_v_q;
	res_t res_q [NB_COUNT];
	logic last_q;

	logic   acc, acc_pix, acc_load;
	col_t   c_a;
	row_t   r_a;
	taddr_t ra_a, ra_inc, la_a;
	logic   prod_a, col_end, row_end, fwd;
	logic   s1_adv;
	pix_t   up_e, mid_e, ctr;
	pix_t   nb [NB_COUNT];

	assign acc      = stream.valid && stream.ready;
	assign acc_pix  = acc && (stream.command == CMD_PIXEL);
	assign acc_load = acc && (stream.command == CMD_LOAD);

	assign s1_adv       = s1_v_q && (!prod_s1 || !o_v_q || result.ready);
	assign stream.ready = !s1_v_q || s1_adv;
	assign cfg.ready    = 1'b1;

	always_comb begin
		if (cfg.data < dim_t'(3)) begin
			width_new = WID_W'(3);
		end else if (int'(cfg.data) > MAX_WIDTH) begin
			width_new = WID_W'(MAX_WIDTH);
		end else begin
			width_new = WID_W'(cfg.data);
		end
	end

	// position of the incoming pixel
	always_comb begin
		c_a     = stream.start_of_frame ? '0 : col_q;
		r_a     = stream.start_of_frame ? '0 : row_q;
		ra_a    = stream.start_of_frame ? '0 : ra_q;
		la_a    = stream.start_of_frame ? '0 : la_q;
		prod_a  = (r_a >= row_t'(2)) && (c_a >= col_t'(2));
		col_end = (CMP_W'(c_a) + CMP_W'(1)) >= CMP_W'(width_q);
		row_end = ({1'b0, r_a} + dim_t'(1)) >= height_q;
		if (prod_a) begin
			ra_inc = (ra_a == TA_LAST) ? '0 : ra_a + taddr_t'(1);
		end else begin
			ra_inc = ra_a;
		end
		// the window stage writes this column at the same edge
		fwd = s1_v_q && (c_a == c_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(WIDTH_RST);
			height_q <= dim_t'(MAX_HEIGHT);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_IMAGE_WIDTH: width_q <= width_new;
				REG_IMAGE_HEIGHT: height_q <= clamp_height(cfg.data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ra_q  <= '0;
			la_q  <= '0;
		end else begin
			if (acc_load) begin
				la_q <= (la_a == TA_LAST) ? '0 : la_a + taddr_t'(1);
			end
			if (acc_pix) begin
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q <= '0;
						ra_q  <= '0;
					end else begin
						row_q <= r_a + row_t'(1);
						ra_q  <= ra_inc;
					end
				end else begin
					col_q <= c_a + col_t'(1);
					row_q <= r_a;
					ra_q  <= ra_inc;
				end
			end
		end
	end

	// template memory: write on load, read at pixel accept
	always_ff @(posedge clk) begin
		if (acc_load) begin
			tmpl_mem[la_a] <= stream.template_bits;
		end
		if (acc_pix) begin
			tmpl_s1 <= tmpl_mem[ra_a];
		end
	end

	// line stores: read at accept, write back from the window stage
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			upper_mem[c_s1]  <= mid_e;
			middle_mem[c_s1] <= px_s1;
		end
		if (acc_pix) begin
			up_rd_s1  <= upper_mem[c_a];
			mid_rd_s1 <= middle_mem[c_a];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_pix) begin
			px_s1      <= stream.pixel;
			c_s1       <= c_a;
			prod_s1    <= prod_a;
			last_s1    <= col_end && row_end;
			vld_s1     <= line_vld_q[c_a];
			fwd_s1     <= fwd;
			fwd_up_s1  <= mid_e;
			fwd_mid_s1 <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q     <= 1'b0;
			line_vld_q <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (acc) begin
				s1_v_q <= (stream.command == CMD_PIXEL);
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				line_vld_q[c_s1] <= 1'b1;
				win_q[0] <= win_q[1];
				win_q[1] <= up_e;
				win_q[2] <= win_q[3];
				win_q[3] <= mid_e;
				win_q[4] <= win_q[5];
				win_q[5] <= px_s1;
			end
		end
	end

	// column above and two above; never-written entries read as zero
	always_comb begin
		if (fwd_s1) begin
			up_e  = fwd_up_s1;
			mid_e = fwd_mid_s1;
		end else if (vld_s1) begin
			up_e  = up_rd_s1;
			mid_e = mid_rd_s1;
		end else begin
			up_e  = '0;
			mid_e = '0;
		end
		ctr   = win_q[3];
		nb[0] = win_q[0];
		nb[1] = win_q[1];
		nb[2] = up_e;
		nb[3] = win_q[2];
		nb[4] = mid_e;
		nb[5] = win_q[4];
		nb[6] = win_q[5];
		nb[7] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (s1_adv && prod_s1) begin
			o_v_q <= 1'b1;
		end else if (result.ready) begin
			o_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && prod_s1) begin
			for (int b = 0; b < NB_COUNT; b++) begin
				res_q[b] <= residual(nb[b], ctr, tmpl_s1[b]);
			end
			last_q <= last_s1;
		end
	end

	assign result.valid         = o_v_q;
	assign result.residual_nw   = res_q[0];
	assign result.residual_n    = res_q[1];
	assign result.residual_ne   = res_q[2];
	assign result.residual_w    = res_q[3];
	assign result.residual_e    = res_q[4];
	assign result.residual_sw   = res_q[5];
	assign result.residual_s    = res_q[6];
	assign result.residual_se   = res_q[7];
	assign result.last_of_frame = last_q;

`ifndef SYNTHESIS
	// the window stage only stalls behind a result that is not taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !s1_adv |-> o_v_q && !result.ready)
		else $error("window stage stalled without a blocked result");

	// a template load never occupies the window stage
	a_load_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		acc_load |=> !s1_v_q)
		else $error("load item entered the window stage");

	// a new result comes only from an interior pixel leaving the window stage
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(o_v_q) |-> $past(s1_v_q && prod_s1))
		else $error("result without an interior pixel");
`endif

endmodule
